// ===== rtl/core/kle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types, sizes and key codes of the keystroke line editor.
// ----------------------------------------------------------------------------
package kle_pkg;

    localparam int LINE_LEN   = 132;
    localparam int HIST_BYTES = 2048;
    localparam int REPEAT_MAX = 255;

    localparam int LINE_AW = $clog2(LINE_LEN + 1);
    localparam int CNT_W   = LINE_AW;
    localparam int HIST_AW = $clog2(HIST_BYTES);
    localparam int REP_W   = 8;

    // Key codes.
    localparam logic [7:0] KEY_SOL    = 8'h01;
    localparam logic [7:0] KEY_BACK   = 8'h02;
    localparam logic [7:0] KEY_DELC   = 8'h04;
    localparam logic [7:0] KEY_EOL    = 8'h05;
    localparam logic [7:0] KEY_FWD    = 8'h06;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_KILL   = 8'h0B;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_NEXT   = 8'h0E;
    localparam logic [7:0] KEY_PREV   = 8'h10;
    localparam logic [7:0] KEY_NOP    = 8'h12;
    localparam logic [7:0] KEY_XPOSE  = 8'h14;
    localparam logic [7:0] KEY_ARG    = 8'h15;
    localparam logic [7:0] KEY_WKILL  = 8'h17;
    localparam logic [7:0] KEY_YANK   = 8'h19;
    localparam logic [7:0] KEY_ESC    = 8'h1B;
    localparam logic [7:0] KEY_RUB    = 8'h7F;
    localparam logic [7:0] KEY_EOF    = 8'h84;
    localparam logic [7:0] KEY_MWBACK = 8'hE2;
    localparam logic [7:0] KEY_MWKILL = 8'hE4;
    localparam logic [7:0] KEY_MWFWD  = 8'hE6;
    localparam logic [7:0] KEY_MBKILL = 8'hE8;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;
    localparam logic [7:0] META_BIT   = 8'h80;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_9    = 8'h39;

    typedef enum logic [1:0] {
        KIND_KEY  = 2'd0,
        KIND_EOI  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } kle_kind_t;

    typedef struct packed {
        kle_kind_t  kind;
        logic [7:0] key_code;
        logic [7:0] char_index;
    } kle_item_t;

    typedef struct packed {
        logic             bell;
        logic             line_done;
        logic             end_of_file;
        logic [CNT_W-1:0] cursor_pos;
        logic [CNT_W-1:0] line_length;
        logic [7:0]       read_char;
    } kle_result_t;

endpackage

// ===== rtl/core/keystroke_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_line_editor
// Emacs-style editor of one text line, driven by one keystroke per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is a keystroke, an end of input, or a read of one line
// byte; each one returns exactly one result transaction. The line, the kill
// buffer and the history ring live in synchronous RAMs, and a sequencer touches
// them one byte at a time, so one transaction at a time is in work. The work of
// an insert, delete or yank grows with the bytes moved or copied, of a word move
// with the bytes scanned, of a history step with the ring bytes passed and
// loaded, and of finishing a line with the line bytes stored. A repeat count
// multiplies the per-pass work. After reset the block zeroes the 2048-byte
// history ring, one byte a cycle, and takes no transaction until it is done.
// A finished result sits in an output register, so the next keystroke is
// accepted while the result still waits on m_tready.
// ----------------------------------------------------------------------------
module keystroke_line_editor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: [7:0] key_code, [15:8] char_index
    input  logic [15:0] s_tdata,
    // s_tuser: [1:0] kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: [0] bell, [1] line_done, [2] end_of_file, [10:3] cursor_pos,
    // [18:11] line_length, [26:19] read_char, [31:27] zero
    output logic [31:0] m_tdata
);
    import kle_pkg::*;

    kle_item_t   item;
    kle_result_t res;
    logic        res_valid;
    logic        res_ready;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    assign item.kind       = kle_kind_t'(s_tuser);
    assign item.key_code   = s_tdata[7:0];
    assign item.char_index = s_tdata[15:8];

    kle_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register frees the engine as soon as a result is parked here.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = 32'({res.read_char, 8'(res.line_length), 8'(res.cursor_pos),
                                res.end_of_file, res.line_done, res.bell});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

// ===== rtl/core/kle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/kle_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_engine
// Edit sequencer: walks line, kill and history memories one byte at a time.
// ----------------------------------------------------------------------------
module kle_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  kle_pkg::kle_item_t   in_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output kle_pkg::kle_result_t res
);
    import kle_pkg::*;

    typedef enum logic [28:0] {
        ST_CLEAR    = 29'h0000001,
        ST_IDLE     = 29'h0000002,
        ST_READ     = 29'h0000004,
        ST_PASS     = 29'h0000008,
        ST_POST     = 29'h0000010,
        ST_CG_START = 29'h0000020,
        ST_CG_RD    = 29'h0000040,
        ST_CG_WR    = 29'h0000080,
        ST_OG_RD    = 29'h0000100,
        ST_OG_WR    = 29'h0000200,
        ST_YK_RD    = 29'h0000400,
        ST_YK_WR    = 29'h0000800,
        ST_KL_RD    = 29'h0001000,
        ST_KL_WR    = 29'h0002000,
        ST_TR_RD1   = 29'h0004000,
        ST_TR_RD2   = 29'h0008000,
        ST_TR_WR1   = 29'h0010000,
        ST_TR_WR2   = 29'h0020000,
        ST_WB_RD    = 29'h0040000,
        ST_WB_CHK   = 29'h0080000,
        ST_WF_RD    = 29'h0100000,
        ST_WF_CHK   = 29'h0200000,
        ST_HS_RD    = 29'h0400000,
        ST_HS_CHK   = 29'h0800000,
        ST_HL_RD    = 29'h1000000,
        ST_HL_CHK   = 29'h2000000,
        ST_HA_RD    = 29'h4000000,
        ST_HA_WR    = 29'h8000000,
        ST_OUT      = 29'h10000000
    } state_t;

    function automatic logic is_word(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic [HIST_AW-1:0] ring_next(input logic [HIST_AW-1:0] p);
        return (p == HIST_AW'(HIST_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [HIST_AW-1:0] ring_prev(input logic [HIST_AW-1:0] p);
        return (p == '0) ? HIST_AW'(HIST_BYTES - 1) : p - 1'b1;
    endfunction

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cursor_reg, cursor_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]   kill_len_reg, kill_len_next;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [HIST_AW-1:0] yp_reg, yp_next;
    logic [HIST_AW-1:0] pp_reg, pp_next;
    logic [HIST_AW-1:0] clr_reg, clr_next;
    logic               meta_reg, meta_next;
    logic [REP_W-1:0]   rep_reg, rep_next;
    logic               coll_arg_reg, coll_arg_next;
    logic               coll_dig_reg, coll_dig_next;
    logic               newline_reg, newline_next;
    logic               bell_reg, bell_next;
    logic               done_reg, done_next;
    logic               eof_reg, eof_next;
    logic               still_reg, still_next;
    logic               ins_reg, ins_next;
    logic               phase_reg, phase_next;
    logic [7:0]         char_reg, char_next;
    logic [7:0]         rd_reg, rd_next;
    logic [7:0]         tmp_reg, tmp_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   t_reg, t_next;

    logic               line_we, kill_we, ring_we;
    logic [LINE_AW-1:0] line_waddr, line_raddr, kill_waddr, kill_raddr;
    logic [7:0]         line_wdata, line_rdata, kill_wdata, kill_rdata;
    logic [7:0]         ring_wdata, ring_rdata;
    logic [HIST_AW-1:0] ring_waddr, ring_raddr;

    logic [CNT_W:0]     i_plus_n, end_plus_n, end_plus_1;
    logic [CNT_W-1:0]   avail, nb;
    logic               w;
    logic               printable;
    logic [REP_W+1:0]   rep_x4;
    logic [11:0]        rep_dec;
    logic [REP_W-1:0]   rep_a;

    kle_ram #(.WIDTH(8), .DEPTH(LINE_LEN + 1)) u_line (
        .aclk (aclk), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
        .raddr(line_raddr), .rdata(line_rdata)
    );

    kle_ram #(.WIDTH(8), .DEPTH(LINE_LEN + 1)) u_kill (
        .aclk (aclk), .we(kill_we), .waddr(kill_waddr), .wdata(kill_wdata),
        .raddr(kill_raddr), .rdata(kill_rdata)
    );

    kle_ram #(.WIDTH(8), .DEPTH(HIST_BYTES)) u_ring (
        .aclk (aclk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
        .raddr(ring_raddr), .rdata(ring_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res.bell        = bell_reg;
    assign res.line_done   = done_reg;
    assign res.end_of_file = eof_reg;
    assign res.cursor_pos  = cursor_reg;
    assign res.line_length = end_reg;
    assign res.read_char   = rd_reg;

    assign i_plus_n   = {1'b0, i_reg} + {1'b0, n_reg};
    assign end_plus_n = {1'b0, end_reg} + {1'b0, n_reg};
    assign end_plus_1 = {1'b0, end_reg} + 1'b1;
    assign avail      = end_reg - cursor_reg;
    assign w          = is_word(line_rdata);
    assign printable  = (char_reg >= PRINT_LO) && (char_reg <= PRINT_HI);
    assign rep_x4     = {rep_reg, 2'b00};
    assign rep_dec    = (coll_dig_reg ? 12'(rep_reg) * 12'd10 : 12'd0) +
                        12'(char_reg - DIGIT_0);

    always_comb begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        end_next      = end_reg;
        kill_len_next = kill_len_reg;
        wp_next       = wp_reg;
        yp_next       = yp_reg;
        pp_next       = pp_reg;
        clr_next      = clr_reg;
        meta_next     = meta_reg;
        rep_next      = rep_reg;
        coll_arg_next = coll_arg_reg;
        coll_dig_next = coll_dig_reg;
        newline_next  = newline_reg;
        bell_next     = bell_reg;
        done_next     = done_reg;
        eof_next      = eof_reg;
        still_next    = still_reg;
        ins_next      = ins_reg;
        phase_next    = phase_reg;
        char_next     = char_reg;
        rd_next       = rd_reg;
        tmp_next      = tmp_reg;
        i_next        = i_reg;
        n_next        = n_reg;
        t_next        = t_reg;
        nb            = '0;
        rep_a         = rep_reg;

        line_we    = 1'b0;
        line_waddr = '0;
        line_wdata = '0;
        line_raddr = t_reg;
        kill_we    = 1'b0;
        kill_waddr = '0;
        kill_wdata = '0;
        kill_raddr = i_reg;
        ring_we    = 1'b0;
        ring_waddr = wp_reg;
        ring_wdata = '0;
        ring_raddr = yp_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                ring_we    = 1'b1;
                ring_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == HIST_AW'(HIST_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                line_raddr = in_item.char_index;
                if (in_valid) begin
                    bell_next = 1'b0;
                    done_next = 1'b0;
                    eof_next  = 1'b0;
                    rd_next   = '0;
                    unique case (in_item.kind)
                        KIND_READ: begin
                            if ({1'b0, in_item.char_index} < {1'b0, end_reg}) begin
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                        KIND_KEY, KIND_EOI: begin
                            if (newline_reg) begin
                                newline_next  = 1'b0;
                                cursor_next   = '0;
                                end_next      = '0;
                                rep_next      = '0;
                                coll_arg_next = 1'b0;
                                coll_dig_next = 1'b0;
                            end
                            if (in_item.kind == KIND_EOI) begin
                                char_next = KEY_CR;
                            end else begin
                                char_next = in_item.key_code | (meta_reg ? META_BIT : 8'h00);
                                meta_next = 1'b0;
                            end
                            state_next = ST_PASS;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_READ: begin
                rd_next    = line_rdata;
                state_next = ST_OUT;
            end

            ST_PASS: begin
                still_next = 1'b0;
                state_next = ST_POST;
                if (!printable) begin
                    unique case (char_reg) inside
                        KEY_SOL: cursor_next = '0;
                        KEY_BACK: begin
                            if (cursor_reg != '0) cursor_next = cursor_reg - 1'b1;
                            else bell_next = 1'b1;
                        end
                        KEY_DELC: begin
                            if (cursor_reg < end_reg) begin
                                n_next     = CNT_W'(1);
                                state_next = ST_CG_START;
                            end else begin
                                bell_next = 1'b1;
                            end
                        end
                        KEY_EOL: cursor_next = end_reg;
                        KEY_FWD: begin
                            if (cursor_reg < end_reg) cursor_next = cursor_reg + 1'b1;
                            else bell_next = 1'b1;
                        end
                        KEY_BS, KEY_RUB: begin
                            if (cursor_reg != '0) begin
                                cursor_next = cursor_reg - 1'b1;
                                n_next      = CNT_W'(1);
                                state_next  = ST_CG_START;
                            end else begin
                                bell_next = 1'b1;
                            end
                        end
                        KEY_LF, KEY_CR: done_next = 1'b1;
                        KEY_KILL: begin
                            n_next     = avail;
                            i_next     = '0;
                            state_next = ST_KL_RD;
                        end
                        KEY_NEXT: state_next = ST_HS_RD;
                        KEY_PREV: begin
                            yp_next    = ring_prev(ring_prev(yp_reg));
                            state_next = ST_HS_RD;
                        end
                        KEY_NOP: ;
                        KEY_XPOSE: begin
                            if (cursor_reg <= CNT_W'(1)) bell_next = 1'b1;
                            else state_next = ST_TR_RD1;
                        end
                        KEY_ARG: begin
                            if (coll_arg_reg) begin
                                rep_next = (rep_x4 > (REP_W + 2)'(REPEAT_MAX)) ?
                                           REP_W'(REPEAT_MAX) : REP_W'(rep_x4);
                            end else begin
                                rep_next = REP_W'(4);
                            end
                            still_next    = 1'b1;
                            coll_dig_next = 1'b0;
                        end
                        KEY_YANK: begin
                            n_next = kill_len_reg;
                            if (({1'b0, end_reg} + {1'b0, kill_len_reg}) >
                                (CNT_W + 1)'(LINE_LEN)) begin
                                bell_next = 1'b1;
                            end else begin
                                i_next     = end_reg;
                                ins_next   = 1'b0;
                                state_next = ST_OG_RD;
                            end
                        end
                        KEY_ESC: meta_next = 1'b1;
                        KEY_MWFWD, KEY_MWKILL: begin
                            if (cursor_reg >= end_reg) bell_next = 1'b1;
                            t_next     = cursor_reg;
                            phase_next = 1'b0;
                            state_next = ST_WF_RD;
                        end
                        KEY_MWBACK, KEY_WKILL, KEY_MBKILL: begin
                            if (cursor_reg != '0) begin
                                t_next = cursor_reg - 1'b1;
                            end else begin
                                t_next    = '0;
                                bell_next = 1'b1;
                            end
                            phase_next = 1'b0;
                            state_next = ST_WB_RD;
                        end
                        KEY_EOF: begin
                            if (end_reg == '0) begin
                                done_next = 1'b1;
                                eof_next  = 1'b1;
                            end else begin
                                bell_next = 1'b1;
                            end
                        end
                        default: bell_next = 1'b1;
                    endcase
                end else if (!coll_arg_reg || char_reg < DIGIT_0 || char_reg > DIGIT_9) begin
                    if (end_plus_1 > (CNT_W + 1)'(LINE_LEN)) begin
                        bell_next = 1'b1;
                    end else begin
                        n_next     = CNT_W'(1);
                        i_next     = end_reg;
                        ins_next   = 1'b1;
                        state_next = ST_OG_RD;
                    end
                end else begin
                    rep_next      = (rep_dec > 12'(REPEAT_MAX)) ? REP_W'(REPEAT_MAX)
                                                                : REP_W'(rep_dec);
                    still_next    = 1'b1;
                    coll_dig_next = 1'b1;
                end
            end

            ST_POST: begin
                if (coll_arg_reg && !still_reg && rep_reg != '0) begin
                    rep_a = rep_reg - 1'b1;
                end
                if (bell_reg) begin
                    rep_a = '0;
                end
                coll_arg_next = still_reg;
                if (!done_reg && !still_reg && rep_a != '0 && char_reg != KEY_ESC) begin
                    rep_next   = rep_a - 1'b1;
                    state_next = ST_PASS;
                end else begin
                    rep_next = rep_a;
                    if (done_reg) begin
                        i_next     = '0;
                        state_next = ST_HA_RD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end

            ST_CG_START: begin
                if (n_reg > avail) begin
                    bell_next = 1'b1;
                    n_next    = avail;
                end
                i_next = cursor_reg;
                if (n_reg == '0 || avail == '0) begin
                    state_next = ST_POST;
                end else begin
                    state_next = ST_CG_RD;
                end
            end

            ST_CG_RD: begin
                line_raddr = LINE_AW'(i_plus_n);
                if (i_plus_n < {1'b0, end_reg}) begin
                    state_next = ST_CG_WR;
                end else begin
                    end_next   = end_reg - n_reg;
                    state_next = ST_POST;
                end
            end

            ST_CG_WR: begin
                line_we    = 1'b1;
                line_waddr = i_reg;
                line_wdata = line_rdata;
                i_next     = i_reg + 1'b1;
                state_next = ST_CG_RD;
            end

            ST_OG_RD: begin
                line_raddr = i_reg - 1'b1;
                if (i_reg > cursor_reg) begin
                    state_next = ST_OG_WR;
                end else begin
                    end_next = CNT_W'(end_plus_n);
                    if (ins_reg) begin
                        line_we     = 1'b1;
                        line_waddr  = cursor_reg;
                        line_wdata  = char_reg;
                        cursor_next = cursor_reg + 1'b1;
                        state_next  = ST_POST;
                    end else begin
                        i_next     = '0;
                        state_next = ST_YK_RD;
                    end
                end
            end

            ST_OG_WR: begin
                line_we    = 1'b1;
                line_waddr = LINE_AW'(i_plus_n - 1'b1);
                line_wdata = line_rdata;
                i_next     = i_reg - 1'b1;
                state_next = ST_OG_RD;
            end

            ST_YK_RD: begin
                if (i_reg < n_reg) begin
                    state_next = ST_YK_WR;
                end else begin
                    cursor_next = cursor_reg + n_reg;
                    state_next  = ST_POST;
                end
            end

            ST_YK_WR: begin
                line_we    = 1'b1;
                line_waddr = cursor_reg + i_reg;
                line_wdata = kill_rdata;
                i_next     = i_reg + 1'b1;
                state_next = ST_YK_RD;
            end

            ST_KL_RD: begin
                line_raddr = cursor_reg + i_reg;
                if (i_reg < n_reg) begin
                    state_next = ST_KL_WR;
                end else begin
                    kill_len_next = n_reg;
                    end_next      = cursor_reg;
                    state_next    = ST_POST;
                end
            end

            ST_KL_WR: begin
                kill_we    = 1'b1;
                kill_waddr = i_reg;
                kill_wdata = line_rdata;
                i_next     = i_reg + 1'b1;
                state_next = ST_KL_RD;
            end

            ST_TR_RD1: begin
                line_raddr = cursor_reg - 1'b1;
                state_next = ST_TR_RD2;
            end

            ST_TR_RD2: begin
                line_raddr = cursor_reg - CNT_W'(2);
                tmp_next   = line_rdata;
                state_next = ST_TR_WR1;
            end

            ST_TR_WR1: begin
                line_we    = 1'b1;
                line_waddr = cursor_reg - 1'b1;
                line_wdata = line_rdata;
                state_next = ST_TR_WR2;
            end

            ST_TR_WR2: begin
                line_we    = 1'b1;
                line_waddr = cursor_reg - CNT_W'(2);
                line_wdata = tmp_reg;
                state_next = ST_POST;
            end

            ST_WB_RD: begin
                state_next = ST_WB_CHK;
            end

            ST_WB_CHK: begin
                if (t_reg != '0 && !phase_reg && !w) begin
                    t_next     = t_reg - 1'b1;
                    state_next = ST_WB_RD;
                end else if (t_reg != '0 && !phase_reg) begin
                    phase_next = 1'b1;
                end else if (t_reg != '0 && w) begin
                    t_next     = t_reg - 1'b1;
                    state_next = ST_WB_RD;
                end else begin
                    nb = cursor_reg - t_reg;
                    if (nb != '0 && !w) begin
                        nb = nb - 1'b1;
                    end
                    cursor_next = cursor_reg - nb;
                    n_next      = nb;
                    state_next  = (char_reg == KEY_MWBACK) ? ST_POST : ST_CG_START;
                end
            end

            ST_WF_RD: begin
                if (t_reg < end_reg) begin
                    state_next = ST_WF_CHK;
                end else if (char_reg == KEY_MWFWD) begin
                    cursor_next = t_reg;
                    state_next  = ST_POST;
                end else begin
                    n_next     = t_reg - cursor_reg;
                    state_next = ST_CG_START;
                end
            end

            ST_WF_CHK: begin
                if (!phase_reg && !w) begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_WF_RD;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else if (w) begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_WF_RD;
                end else if (char_reg == KEY_MWFWD) begin
                    cursor_next = t_reg;
                    state_next  = ST_POST;
                end else begin
                    n_next     = t_reg - cursor_reg;
                    state_next = ST_CG_START;
                end
            end

            ST_HS_RD: begin
                state_next = ST_HS_CHK;
            end

            ST_HS_CHK: begin
                if (ring_rdata != 8'h00) begin
                    yp_next    = (char_reg == KEY_PREV) ? ring_prev(yp_reg) : ring_next(yp_reg);
                    state_next = ST_HS_RD;
                end else begin
                    yp_next    = ring_next(yp_reg);
                    pp_next    = ring_next(yp_reg);
                    i_next     = '0;
                    state_next = ST_HL_RD;
                end
            end

            ST_HL_RD: begin
                ring_raddr = pp_reg;
                if (i_reg < CNT_W'(LINE_LEN)) begin
                    state_next = ST_HL_CHK;
                end else begin
                    cursor_next = i_reg;
                    end_next    = i_reg;
                    state_next  = ST_POST;
                end
            end

            ST_HL_CHK: begin
                ring_raddr = pp_reg;
                if (ring_rdata != 8'h00) begin
                    line_we    = 1'b1;
                    line_waddr = i_reg;
                    line_wdata = ring_rdata;
                    i_next     = i_reg + 1'b1;
                    pp_next    = ring_next(pp_reg);
                    state_next = ST_HL_RD;
                end else begin
                    cursor_next = i_reg;
                    end_next    = i_reg;
                    state_next  = ST_POST;
                end
            end

            ST_HA_RD: begin
                line_raddr = i_reg;
                if (i_reg < end_reg) begin
                    state_next = ST_HA_WR;
                end else begin
                    ring_we      = 1'b1;
                    ring_waddr   = wp_reg;
                    ring_wdata   = 8'h00;
                    wp_next      = ring_next(wp_reg);
                    yp_next      = ring_next(wp_reg);
                    newline_next = 1'b1;
                    state_next   = ST_OUT;
                end
            end

            ST_HA_WR: begin
                ring_we    = 1'b1;
                ring_waddr = wp_reg;
                ring_wdata = line_rdata;
                wp_next    = ring_next(wp_reg);
                i_next     = i_reg + 1'b1;
                state_next = ST_HA_RD;
            end

            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cursor_reg   <= '0;
            end_reg      <= '0;
            kill_len_reg <= '0;
            wp_reg       <= '0;
            yp_reg       <= '0;
            clr_reg      <= '0;
            meta_reg     <= 1'b0;
            rep_reg      <= '0;
            coll_arg_reg <= 1'b0;
            coll_dig_reg <= 1'b0;
            newline_reg  <= 1'b1;
            bell_reg     <= 1'b0;
            done_reg     <= 1'b0;
            eof_reg      <= 1'b0;
            still_reg    <= 1'b0;
            ins_reg      <= 1'b0;
            phase_reg    <= 1'b0;
            rd_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            end_reg      <= end_next;
            kill_len_reg <= kill_len_next;
            wp_reg       <= wp_next;
            yp_reg       <= yp_next;
            clr_reg      <= clr_next;
            meta_reg     <= meta_next;
            rep_reg      <= rep_next;
            coll_arg_reg <= coll_arg_next;
            coll_dig_reg <= coll_dig_next;
            newline_reg  <= newline_next;
            bell_reg     <= bell_next;
            done_reg     <= done_next;
            eof_reg      <= eof_next;
            still_reg    <= still_next;
            ins_reg      <= ins_next;
            phase_reg    <= phase_next;
            rd_reg       <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        pp_reg   <= pp_next;
        char_reg <= char_next;
        tmp_reg  <= tmp_next;
        i_reg    <= i_next;
        n_reg    <= n_next;
        t_reg    <= t_next;
    end
endmodule
